>>> hdl/pru_pkg.sv
// Package for the pixel replicating upscaler with grid overlay.
// Holds the field widths, blend constants, size clamps and the divider request/response types.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pru_pkg;

  // Size limits and field widths.
  localparam int unsigned MAX_SRC_DIM = 4096;
  localparam int unsigned MAX_RUN     = 16;
  localparam int unsigned SRC_W       = 13;  // source size registers
  localparam int unsigned CNT_W       = 12;  // source column and row counters
  localparam int unsigned DST_W       = 16;  // destination sizes and coordinates
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned RUN_W       = $clog2(MAX_RUN + 1);
  localparam int unsigned PROD_W      = SRC_W + DST_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DST_W + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 3;

  // Grid blend: (p * 156 + 128 * 100) >> 8.
  localparam int unsigned GRID_GREY   = 128;
  localparam int unsigned PIX_WEIGHT  = 156;
  localparam int unsigned GRID_WEIGHT = 100;
  localparam int unsigned BLEND_SHIFT = 8;

  // Request to the shared multiply and divide unit: quot = mul_a * mul_b / divisor.
  typedef struct packed {
    logic             start;
    logic [SRC_W-1:0] mul_a;
    logic [DST_W-1:0] mul_b;
    logic [SRC_W-1:0] divisor;
  } div_req_t;

  // Response: done pulses for one cycle while quot holds the result.
  typedef struct packed {
    logic             done;
    logic [DST_W-1:0] quot;
  } div_rsp_t;

  // Source sizes of zero act as one, sizes above the limit act as the limit.
  function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v);
    logic [SRC_W-1:0] r;
    if (v == '0) begin
      r = SRC_W'(1);
    end else if (v > SRC_W'(MAX_SRC_DIM)) begin
      r = SRC_W'(MAX_SRC_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Destination sizes of zero act as one.
  function automatic logic [DST_W-1:0] clamp_dst(input logic [DST_W-1:0] v);
    return (v == '0) ? DST_W'(1) : v;
  endfunction

  // Grey value of a grid pixel; the sum stays below 2^16.
  function automatic logic [PIX_W-1:0] grid_blend(input logic [PIX_W-1:0] p);
    logic [15:0] t;
    t = 16'(p) * 16'(PIX_WEIGHT) + 16'(GRID_GREY * GRID_WEIGHT);
    return t[BLEND_SHIFT +: PIX_W];
  endfunction

endpackage

`default_nettype wire

>>> hdl/pru_div.sv
// Shared multiply and restoring divide unit of the upscaler.
// Computes a * b / d with one registered multiply and one quotient bit per cycle.
// Depends on pru_pkg.
`default_nettype none

module pru_div
  import pru_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_RUN} div_state_e;

  div_state_e           state_q;
  logic [SRC_W-1:0]     a_q;
  logic [DST_W-1:0]     b_q;
  logic [SRC_W-1:0]     dvs_q;
  logic [SRC_W-1:0]     rem_q;
  logic [DST_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;

  logic [PROD_W-1:0]    prod;
  logic [SRC_W:0]       trial;
  logic [SRC_W:0]       diff;
  logic                 fits;

  // The caller keeps the quotient below 2^DST_W, so the upper product bits
  // already lie below the divisor and only DST_W steps are needed.
  assign prod  = PROD_W'(a_q) * PROD_W'(b_q);
  assign trial = {rem_q, quo_q[DST_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  // Sequencer: take the operands, multiply, then shift in one quotient bit a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      dvs_q   <= SRC_W'(1);
      rem_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            a_q     <= req_i.mul_a;
            b_q     <= req_i.mul_b;
            dvs_q   <= req_i.divisor;
            state_q <= D_MUL;
          end
        end
        D_MUL: begin
          rem_q   <= prod[PROD_W-1:DST_W];
          quo_q   <= prod[DST_W-1:0];
          cnt_q   <= DIV_CNT_W'(DST_W);
          state_q <= D_RUN;
        end
        D_RUN: begin
          rem_q <= fits ? diff[SRC_W-1:0] : trial[SRC_W-1:0];
          quo_q <= {quo_q[DST_W-2:0], fits};
          cnt_q <= cnt_q - DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

>>> hdl/pixel_replicate_upscale_with_grid_unit.sv
// Top level of the pixel replicating upscaler with grid overlay.
// Instantiates pru_div as its one shared multiply and divide unit; depends on pru_pkg.
//
// Use of the block:
//   The slave stream takes one 8-bit grey source pixel per word, row-major. The
//   feeder replays source row next_src_row once for every destination row it
//   covers; every result word reports which source row must come next.
//   The master stream returns, for each source pixel, its run of destination
//   pixels (at most 16), with coordinates, a grid flag and row and frame ends.
//   The last column of every run and the last row of every row span are grid
//   pixels and carry the blended grey value.
//   The configuration channel writes the four size registers; it is always
//   ready and is to be used only while the block is idle.
//   Two divisions by the shared divider (16 quotient bits, one a cycle) set
//   the run ends of each pixel, then the run leaves at one word a cycle while
//   the receiver is ready. Each change of source row adds one more division,
//   and each source row that covers no destination row one more again. Only
//   one pixel is in work at a time; s_axis_tready is low from acceptance to
//   the last result word. If the receiver stalls, the current result word is
//   held until taken.
//   After reset all counters are zero and the sizes read 540 x 960 to
//   540 x 960; the row span is worked out with the first pixel.
`default_nettype none

module pixel_replicate_upscale_with_grid_unit
  import pru_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write channel.
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Source pixel stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
  // Destination pixel stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [7:0] out_pixel, [23:8] dst_x, [39:24] dst_y, [51:40] next_src_row, [55:52] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast,   // last_of_run
  // [0] is_grid, [1] end_of_row, [2] end_of_frame
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser
);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT,
    CFG_DST_WIDTH,
    CFG_DST_HEIGHT
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW_DIV,
    S_ROW_WAIT,
    S_COL0,
    S_COL0_WAIT,
    S_COL1,
    S_COL1_WAIT,
    S_ADVANCE,
    S_EMIT_PREP,
    S_EMIT
  } state_e;

  // Configuration registers.
  logic [SRC_W-1:0] src_width_q, src_height_q;
  logic [DST_W-1:0] dst_width_q, dst_height_q;

  // Sequencer state and counters.
  state_e           state_q;
  logic [CNT_W-1:0] src_col_q, src_row_q;
  logic [DST_W-1:0] dst_row_q, dst_row_end_q, dst_col_start_q, dx_end_q, row_q;
  logic [PIX_W-1:0] pix_q;
  logic             restart_q, ret_emit_q;
  logic             grid_row_q, last_col_q, last_frame_row_q;
  logic [RUN_W-1:0] n_q, k_q;

  // Derived values.
  logic [SRC_W-1:0] sw, sh;
  logic [DST_W-1:0] dw, dh;
  logic [SRC_W-1:0] src_col_inc, src_row_inc;
  logic [DST_W:0]   dst_row_inc;
  logic             row_bad, need_settle, end_low, row_has_next, last_col;
  logic [DST_W-1:0] run_len;
  logic [RUN_W-1:0] k_inc;
  logic             last, grid;
  logic [DST_W-1:0] col;
  logic [PIX_W-1:0] out_pix;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration writes; the channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_W'(540);
      src_height_q <= SRC_W'(960);
      dst_width_q  <= DST_W'(540);
      dst_height_q <= DST_W'(960);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SRC_W-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[SRC_W-1:0];
        CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i[DST_W-1:0];
        CFG_DST_HEIGHT: dst_height_q <= cfg_data_i[DST_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes and counter comparisons.
  assign sw = clamp_src(src_width_q);
  assign sh = clamp_src(src_height_q);
  assign dw = clamp_dst(dst_width_q);
  assign dh = clamp_dst(dst_height_q);

  assign src_col_inc  = {1'b0, src_col_q} + SRC_W'(1);
  assign src_row_inc  = {1'b0, src_row_q} + SRC_W'(1);
  assign dst_row_inc  = {1'b0, dst_row_q} + (DST_W+1)'(1);
  assign row_bad      = {1'b0, src_row_q} >= sh;
  assign need_settle  = row_bad || (dst_row_end_q <= dst_row_q);
  assign end_low      = div_rsp.quot <= dst_row_q;
  assign row_has_next = src_row_inc < sh;
  assign last_col     = src_col_inc == sw;
  assign run_len      = dx_end_q - dst_col_start_q;

  // Operands for the shared divider, chosen by the sequencer state.
  always_comb begin
    div_req.start   = 1'b0;
    div_req.mul_a   = src_row_inc;
    div_req.mul_b   = dh;
    div_req.divisor = sh;
    unique case (state_q)
      S_ROW_DIV: begin
        div_req.start = 1'b1;
      end
      S_COL0: begin
        div_req.start   = 1'b1;
        div_req.mul_a   = {1'b0, src_col_q};
        div_req.mul_b   = dw;
        div_req.divisor = sw;
      end
      S_COL1: begin
        div_req.start   = 1'b1;
        div_req.mul_a   = src_col_inc;
        div_req.mul_b   = dw;
        div_req.divisor = sw;
      end
      default: ;
    endcase
  end

  pru_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Main sequencer: settle the row span, find the run, advance, then emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      src_col_q        <= '0;
      src_row_q        <= '0;
      dst_row_q        <= '0;
      dst_row_end_q    <= '0;
      dst_col_start_q  <= '0;
      dx_end_q         <= '0;
      row_q            <= '0;
      pix_q            <= '0;
      restart_q        <= 1'b0;
      ret_emit_q       <= 1'b0;
      grid_row_q       <= 1'b0;
      last_col_q       <= 1'b0;
      last_frame_row_q <= 1'b0;
      n_q              <= '0;
      k_q              <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pix_q <= s_axis_tdata;
            if ({1'b0, src_col_q} >= sw) begin
              src_col_q <= '0;
            end
            if (row_bad) begin
              src_row_q <= '0;
              dst_row_q <= '0;
            end
            restart_q  <= 1'b0;
            ret_emit_q <= 1'b0;
            state_q    <= need_settle ? S_ROW_DIV : S_COL0;
          end
        end
        S_ROW_DIV: begin
          state_q <= S_ROW_WAIT;
        end
        // Skip source rows that cover no destination row; restart the frame
        // once if none is left.
        S_ROW_WAIT: begin
          if (div_rsp.done) begin
            if (end_low && row_has_next) begin
              src_row_q <= src_row_inc[CNT_W-1:0];
              state_q   <= S_ROW_DIV;
            end else if (end_low && !restart_q) begin
              src_row_q <= '0;
              dst_row_q <= '0;
              restart_q <= 1'b1;
              state_q   <= S_ROW_DIV;
            end else begin
              dst_row_end_q <= div_rsp.quot;
              state_q       <= ret_emit_q ? S_EMIT_PREP : S_COL0;
            end
          end
        end
        S_COL0: begin
          state_q <= S_COL0_WAIT;
        end
        S_COL0_WAIT: begin
          if (div_rsp.done) begin
            dst_col_start_q <= div_rsp.quot;
            state_q         <= S_COL1;
          end
        end
        S_COL1: begin
          state_q <= S_COL1_WAIT;
        end
        S_COL1_WAIT: begin
          if (div_rsp.done) begin
            dx_end_q <= div_rsp.quot;
            state_q  <= S_ADVANCE;
          end
        end
        // Capture the run's flags, then step the source and destination counters.
        S_ADVANCE: begin
          n_q              <= (run_len > DST_W'(MAX_RUN)) ? RUN_W'(MAX_RUN)
                                                          : run_len[RUN_W-1:0];
          row_q            <= dst_row_q;
          grid_row_q       <= dst_row_inc == {1'b0, dst_row_end_q};
          last_col_q       <= last_col;
          last_frame_row_q <= (dst_row_inc == {1'b0, dst_row_end_q}) && (src_row_inc == sh);
          if (last_col) begin
            src_col_q <= '0;
            if (dst_row_inc >= {1'b0, dst_row_end_q}) begin
              if (src_row_inc >= sh) begin
                src_row_q <= '0;
                dst_row_q <= '0;
              end else begin
                src_row_q <= src_row_inc[CNT_W-1:0];
                dst_row_q <= dst_row_inc[DST_W-1:0];
              end
              restart_q  <= 1'b0;
              ret_emit_q <= 1'b1;
              state_q    <= S_ROW_DIV;
            end else begin
              dst_row_q <= dst_row_inc[DST_W-1:0];
              state_q   <= S_EMIT_PREP;
            end
          end else begin
            src_col_q <= src_col_inc[CNT_W-1:0];
            state_q   <= S_EMIT_PREP;
          end
        end
        S_EMIT_PREP: begin
          k_q     <= '0;
          state_q <= (n_q == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (m_axis_tready) begin
            if (last) begin
              state_q <= S_IDLE;
            end else begin
              k_q <= k_inc;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result word of step k: the last step of a run jumps to the run's grid column.
  assign k_inc   = k_q + RUN_W'(1);
  assign last    = k_inc == n_q;
  assign col     = last ? (dx_end_q - DST_W'(1)) : (dst_col_start_q + DST_W'(k_q));
  assign grid    = grid_row_q || last;
  assign out_pix = grid ? grid_blend(pix_q) : pix_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_EMIT);
  assign m_axis_tdata  = {4'b0000, src_row_q, row_q, col, out_pix};
  assign m_axis_tlast  = last;
  assign m_axis_tuser  = {last && last_col_q && last_frame_row_q, last && last_col_q, grid};

  // Checks on the sequencer.
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while results are pending");

  a_step_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (k_q < n_q))
    else $error("run step beyond run length");

  a_row_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (dst_row_q < dst_row_end_q))
    else $error("destination row outside its row span");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block not idle after last word of a run");

  a_div_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == S_ROW_WAIT) || (state_q == S_COL0_WAIT) ||
                      (state_q == S_COL1_WAIT)))
    else $error("divider result arrived unawaited");

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pixel replicating upscaler with grid overlay.
// Depends on pru_pkg and pixel_replicate_upscale_with_grid_unit; a built-in predictor checks
// every destination word against its own sizes and counters or the directed table's word.

module tb;
  import pru_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 128;
  localparam int unsigned SETTLE_CYCLES = 600;   // one pixel with row skips, with margin
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned REPORT_MAX    = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } cfg_reg_e;

  // One destination word as it leaves the master stream.
  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic [DST_W-1:0] dst_x;
    logic [DST_W-1:0] dst_y;
    logic             is_grid;
    logic             last_of_run;
    logic             end_of_row;
    logic             end_of_frame;
    logic [CNT_W-1:0] next_src_row;
  } dst_pixel_t;

  // A row of the directed table: a size setting or a source pixel.
  typedef struct {
    bit                           is_cfg;
    logic [3:0][CFG_DATA_W-1:0]   sizes;   // [0] src width ... [3] dst height
    logic [PIX_W-1:0]             pixel;
    bit                           typed;   // expected word given in the table
    dst_pixel_t                   want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  bit no_idle = 1'b0;   // stretch in which neither side holds back

  dst_pixel_t  pending_dst_q[$];
  int unsigned src_pixels_sent   = 0;
  int unsigned dst_words_checked = 0;
  int unsigned size_settings     = 0;
  int unsigned mismatches        = 0;
  int unsigned quiet_cycles      = 0;

  // Predictor copy of the size registers and the scan counters.
  logic [SRC_W-1:0] sw_reg = SRC_W'(540);
  logic [SRC_W-1:0] sh_reg = SRC_W'(960);
  logic [DST_W-1:0] dw_reg = DST_W'(540);
  logic [DST_W-1:0] dh_reg = DST_W'(960);
  int unsigned col_cnt      = 0;
  int unsigned row_cnt      = 0;
  int unsigned dst_row_cnt  = 0;
  int unsigned row_span_end = 0;

  pixel_replicate_upscale_with_grid_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Source sizes of zero count as one; anything above the limit counts as the limit.
  function automatic int unsigned src_size(input logic [SRC_W-1:0] v);
    if (v == '0) return 1;
    if (v > SRC_W'(MAX_SRC_DIM)) return MAX_SRC_DIM;
    return 32'(v);
  endfunction

  // Find the destination row where the current source row span ends, skipping
  // source rows that cover no destination row and restarting the frame if none fits.
  function automatic void fix_row_span(input int unsigned sh, input int unsigned dh);
    int unsigned span_end;
    if (row_cnt >= sh) begin
      row_cnt = 0;
      dst_row_cnt = 0;
    end
    span_end = (row_cnt + 1) * dh / sh;
    while (span_end <= dst_row_cnt && row_cnt + 1 < sh) begin
      row_cnt++;
      span_end = (row_cnt + 1) * dh / sh;
    end
    if (span_end <= dst_row_cnt) begin
      row_cnt = 0;
      dst_row_cnt = 0;
      span_end = dh / sh;
      while (span_end == 0 && row_cnt + 1 < sh) begin
        row_cnt++;
        span_end = (row_cnt + 1) * dh / sh;
      end
    end
    row_span_end = span_end;
  endfunction

  // Work out the run of destination words that one source pixel produces.
  function automatic void upscale_pixel(input logic [PIX_W-1:0] p, ref dst_pixel_t run_q[$]);
    int unsigned sw, sh, dw, dh, x_first, x_end, run, n, y, k;
    logic [PIX_W-1:0] grey;
    bit grid_row, last_col, last_frame_row, last;
    dst_pixel_t d;
    sw = src_size(sw_reg);
    sh = src_size(sh_reg);
    dw = (dw_reg == '0) ? 1 : int'(dw_reg);
    dh = (dh_reg == '0) ? 1 : int'(dh_reg);
    grey = PIX_W'((int'(p) * PIX_WEIGHT + GRID_GREY * GRID_WEIGHT) >> BLEND_SHIFT);
    run_q.delete();

    // A column past the width (after a size change) restarts the row.
    if (col_cnt >= sw) col_cnt = 0;
    if (row_cnt >= sh || row_span_end <= dst_row_cnt) fix_row_span(sh, dh);

    x_first = col_cnt * dw / sw;
    x_end = (col_cnt + 1) * dw / sw;
    run = x_end - x_first;
    n = (run > MAX_RUN) ? MAX_RUN : run;
    y = dst_row_cnt;
    grid_row = (y + 1 == row_span_end);
    last_col = (col_cnt + 1 == sw);
    last_frame_row = grid_row && (row_cnt + 1 == sh);

    // Step the scan position on to the next source pixel.
    col_cnt++;
    if (col_cnt >= sw) begin
      col_cnt = 0;
      dst_row_cnt++;
      if (dst_row_cnt >= row_span_end) begin
        row_cnt++;
        if (row_cnt >= sh) begin
          row_cnt = 0;
          dst_row_cnt = 0;
        end
        fix_row_span(sh, dh);
      end
    end

    // A cut run keeps its first columns and then its last, grid, column.
    for (k = 0; k < n; k++) begin
      last = (k + 1 == n);
      d.out_pixel    = (grid_row || last) ? grey : p;
      d.dst_x        = DST_W'(last ? x_end - 1 : x_first + k);
      d.dst_y        = DST_W'(y);
      d.is_grid      = grid_row || last;
      d.last_of_run  = last;
      d.end_of_row   = last && last_col;
      d.end_of_frame = last && last_col && last_frame_row;
      d.next_src_row = CNT_W'(row_cnt);
      run_q.push_back(d);
    end
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_DATA_W-1:0] sw, sh, dw, dh);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.sizes = {dh, dw, sh, sw};
    return r;
  endfunction

  function automatic stim_row_t pix_row(input logic [PIX_W-1:0] p);
    stim_row_t r;
    r = '{default: '0};
    r.pixel = p;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [PIX_W-1:0] p, input dst_pixel_t w);
    stim_row_t r;
    r = pix_row(p);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic void report_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("Mismatch in %s of word %0d: expected %0d, got %0d",
               field, dst_words_checked, want, got);
  endfunction

  // Wait for the block to go idle, then write all four size registers.
  task automatic set_sizes(input logic [3:0][CFG_DATA_W-1:0] sizes);
    int i;
    s_axis_tvalid <= 1'b0;
    while (pending_dst_q.size() != 0) @(posedge clk_i);
    // A last pixel without any word may still be in work.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i  <= sizes[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (cfg_reg_e'(i))
        REG_SRC_WIDTH:  sw_reg = sizes[i][SRC_W-1:0];
        REG_SRC_HEIGHT: sh_reg = sizes[i][SRC_W-1:0];
        REG_DST_WIDTH:  dw_reg = sizes[i];
        REG_DST_HEIGHT: dh_reg = sizes[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
    size_settings++;
  endtask

  // Offer one source pixel, idling at random first, and queue its words once taken.
  task automatic send_pixel(input stim_row_t row);
    dst_pixel_t run_q[$];
    while (!no_idle && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.pixel;
    do @(posedge clk_i); while (!s_axis_tready);
    upscale_pixel(row.pixel, run_q);
    if (row.typed) pending_dst_q.push_back(row.want);
    else foreach (run_q[i]) pending_dst_q.push_back(run_q[i]);
    src_pixels_sent++;
  endtask

  // Receiver: random back-pressure and a field-by-field check of every word.
  always @(posedge clk_i) begin
    dst_pixel_t got, want;
    if (rst_ni) m_axis_tready <= no_idle || ($urandom_range(99) >= 14);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_pixel    = m_axis_tdata[7:0];
      got.dst_x        = m_axis_tdata[23:8];
      got.dst_y        = m_axis_tdata[39:24];
      got.next_src_row = m_axis_tdata[51:40];
      got.last_of_run  = m_axis_tlast;
      got.is_grid      = m_axis_tuser[0];
      got.end_of_row   = m_axis_tuser[1];
      got.end_of_frame = m_axis_tuser[2];
      if (pending_dst_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Word with nothing pending: tdata=%h tlast=%b tuser=%b",
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = pending_dst_q.pop_front();
        if (got.out_pixel !== want.out_pixel)
          report_mismatch("out_pixel", want.out_pixel, got.out_pixel);
        if (got.dst_x !== want.dst_x) report_mismatch("dst_x", want.dst_x, got.dst_x);
        if (got.dst_y !== want.dst_y) report_mismatch("dst_y", want.dst_y, got.dst_y);
        if (got.is_grid !== want.is_grid)
          report_mismatch("is_grid", want.is_grid, got.is_grid);
        if (got.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
        if (got.end_of_row !== want.end_of_row)
          report_mismatch("end_of_row", want.end_of_row, got.end_of_row);
        if (got.end_of_frame !== want.end_of_frame)
          report_mismatch("end_of_frame", want.end_of_frame, got.end_of_frame);
        if (got.next_src_row !== want.next_src_row)
          report_mismatch("next_src_row", want.next_src_row, got.next_src_row);
      end
      dst_words_checked++;
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d words still pending",
               QUIET_LIMIT, pending_dst_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed table, then random size settings each with a burst of pixels.
  initial begin
    stim_row_t directed_tbl[$];
    logic [3:0][CFG_DATA_W-1:0] sz;
    int unsigned sw, sh, dw, dh, items, kind, random_pixels;

    // Reset sizes: one destination pixel per source pixel, every pixel on the grid.
    directed_tbl.push_back(typed_row(8'h00,
      dst_pixel_t'{8'd50, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 12'd0}));
    directed_tbl.push_back(typed_row(8'hFF,
      dst_pixel_t'{8'd205, 16'd1, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 12'd0}));
    directed_tbl.push_back(pix_row(8'h5A));
    // One by one image: every pixel closes its row and its frame.
    directed_tbl.push_back(cfg_row(16'd1, 16'd1, 16'd1, 16'd1));
    directed_tbl.push_back(typed_row(8'h00,
      dst_pixel_t'{8'd50, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 12'd0}));
    directed_tbl.push_back(typed_row(8'hFF,
      dst_pixel_t'{8'd205, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 12'd0}));
    // Zero sizes act as one.
    directed_tbl.push_back(cfg_row(16'd0, 16'd0, 16'd0, 16'd0));
    directed_tbl.push_back(pix_row(8'hA5));
    // Largest sizes; an over-range source width is clamped.
    directed_tbl.push_back(cfg_row(16'hFFFF, 16'd4096, 16'hFFFF, 16'hFFFF));
    directed_tbl.push_back(pix_row(8'hC3));
    directed_tbl.push_back(pix_row(8'h3C));
    directed_tbl.push_back(pix_row(8'h81));
    // One source column across the full width: every run is cut.
    directed_tbl.push_back(cfg_row(16'd1, 16'd2, 16'hFFFF, 16'd3));
    directed_tbl.push_back(pix_row(8'h01));
    directed_tbl.push_back(pix_row(8'h80));
    directed_tbl.push_back(pix_row(8'hFE));
    directed_tbl.push_back(pix_row(8'h7F));
    // Downscaling: empty runs and a source row that covers no destination row.
    directed_tbl.push_back(cfg_row(16'd5, 16'd4, 16'd2, 16'd3));
    directed_tbl.push_back(pix_row(8'h11));
    directed_tbl.push_back(pix_row(8'h22));
    directed_tbl.push_back(pix_row(8'h44));
    directed_tbl.push_back(pix_row(8'h88));
    directed_tbl.push_back(pix_row(8'hF0));
    directed_tbl.push_back(pix_row(8'h0F));
    directed_tbl.push_back(pix_row(8'h99));
    directed_tbl.push_back(pix_row(8'h66));
    directed_tbl.push_back(pix_row(8'hEE));
    directed_tbl.push_back(pix_row(8'h77));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].is_cfg) set_sizes(directed_tbl[i].sizes);
      else send_pixel(directed_tbl[i]);
    end

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        // Small upscaled images, fed long enough to run through a frame, up to a cap of 60 pixels.
        sw = $urandom_range(1, 6);
        sh = $urandom_range(1, 5);
        dw = sw * $urandom_range(1, 4) + $urandom_range(0, sw - 1);
        dh = sh * $urandom_range(1, 4) + $urandom_range(0, sh - 1);
        items = sw * dh + $urandom_range(0, 4);
        if (items > 60) items = 60;
      end else if (kind < 85) begin
        // Wide destination: runs of 13 or more words, most of them over the cut length.
        sw = $urandom_range(1, 3);
        sh = $urandom_range(1, 2);
        dw = $urandom_range(40, 2000);
        dh = $urandom_range(1, 4);
        items = sw * dh + 2;
      end else begin
        // Downscaling, zero sizes included.
        sw = $urandom_range(2, 8);
        sh = $urandom_range(2, 6);
        dw = $urandom_range(0, sw);
        dh = $urandom_range(0, sh);
        items = $urandom_range(12, 24);
      end
      // The last burst stops at the planned pixel count.
      if (items > RANDOM_PIXELS - random_pixels) items = RANDOM_PIXELS - random_pixels;
      sz = {CFG_DATA_W'(dh), CFG_DATA_W'(dw), CFG_DATA_W'(sh), CFG_DATA_W'(sw)};
      set_sizes(sz);
      repeat (items) begin
        no_idle <= (random_pixels >= 40 && random_pixels < 90);
        send_pixel(pix_row(PIX_W'($urandom_range(0, 255))));
        random_pixels++;
      end
    end

    // Drain: every expected word, then time for anything stray to show.
    s_axis_tvalid <= 1'b0;
    while (pending_dst_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d source pixels over %0d size settings, %0d words checked.",
             src_pixels_sent, size_settings, dst_words_checked);
    $display("Field mismatches and stray words: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> pixel_replicate_upscale_with_grid_unit.f
hdl/pru_pkg.sv
hdl/pru_div.sv
hdl/pixel_replicate_upscale_with_grid_unit.sv
sim/tb.sv
